/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty bodies when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on clk, disabled while arst_n is low
`define DCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on clk at every edge, reset included
`define DCS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCS_ASSERT(lbl, prop, msg)
`define DCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/dcs_pkg.sv */
// ---------------------------------------------------------------------------
// dcs_pkg
// Types and constants of the discrete CDF sampler.
// ---------------------------------------------------------------------------
package dcs_pkg;

	// table geometry
	localparam int MAX_STATES = 256;
	localparam int IDX_W      = $clog2(MAX_STATES);

	// field widths
	localparam int WEIGHT_W = 32;
	localparam int NST_W    = 9;
	localparam int MULT_W   = 17;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W   = 2 * WEIGHT_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULT_Z      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MULT_W      = 2'd2;

	// reset values
	localparam logic [NST_W-1:0]    NUM_STATES_RST = 9'd1;
	localparam logic [MULT_W-1:0]   MULT_Z_RST     = 17'd18000;
	localparam logic [MULT_W-1:0]   MULT_W_RST     = 17'd18030;
	localparam logic [WEIGHT_W-1:0] GEN_Z_SEED     = 32'd362436069;
	localparam logic [WEIGHT_W-1:0] GEN_W_SEED     = 32'd521288629;

	// request kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_GZ,
		S_GW,
		S_PROD,
		S_SRCH,
		S_DONE
	} state_t;

endpackage

/* sv/dcs_ifs.sv */
// ---------------------------------------------------------------------------
// dcs channel interfaces
// Valid/ready request and response channels of the sampler.
// ---------------------------------------------------------------------------

// request channel: table loads and draws
interface dcs_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  entry_index;
	logic [31:0] cumulative_weight;

	modport source (output valid, output kind, output entry_index,
		output cumulative_weight, input ready);
	modport sink (input valid, input kind, input entry_index,
		input cumulative_weight, output ready);
endinterface

// response channel: one result per draw
interface dcs_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  sample_index;
	logic [31:0] random_word;

	modport source (output valid, output sample_index, output random_word, input ready);
	modport sink (input valid, input sample_index, input random_word, output ready);
endinterface

/* sv/dcs_ram.sv */
// ---------------------------------------------------------------------------
// dcs_ram
// Cumulative weight table: one write port, one registered read port.
// ---------------------------------------------------------------------------
module dcs_ram
	import dcs_pkg::*;
(
	input  logic                clk,
	input  logic                we,
	input  logic [IDX_W-1:0]    waddr,
	input  logic [WEIGHT_W-1:0] wdata,
	input  logic [IDX_W-1:0]    raddr,
	output logic [WEIGHT_W-1:0] rdata
);

	logic [WEIGHT_W-1:0] mem [MAX_STATES];
	logic [WEIGHT_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/dcs_mul.sv */
// ---------------------------------------------------------------------------
// dcs_mul
// Shared multiply-add unit: p = a * b + c, registered, holds when idle.
// ---------------------------------------------------------------------------
module dcs_mul
	import dcs_pkg::*;
(
	input  logic                clk,
	input  logic                en,
	input  logic [WEIGHT_W-1:0] a,
	input  logic [WEIGHT_W-1:0] b,
	input  logic [WEIGHT_W-1:0] c,
	output logic [PROD_W-1:0]   p
);

	logic [PROD_W-1:0] p_s1;

	// one 32x32 product plus addend per enabled cycle
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= PROD_W'(a) * PROD_W'(b) + PROD_W'(c);
		end
	end

	assign p = p_s1;

endmodule

/* sv/discrete_cdf_sampler_mwc.sv */
// ---------------------------------------------------------------------------
// discrete_cdf_sampler_mwc
// Inverse-CDF sampler with two multiply-with-carry generators.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one request at a time. kind 0 stores cumulative_weight at
//   entry_index in the table and gives no response.
//   kind 1 draws: both generators step, the 32-bit word U is formed, the
//   last weight is scaled by U / 2^32 and the table is binary-searched.
//   rsp returns sample_index and random_word for each draw.
//   rsp.valid rises once a draw has passed states GZ, GW and PROD, the
//   k search probes, k at most ceil(log2(num_states)), and DONE; the next
//   request is taken once the sequencer is back in IDLE. The shared
//   multiplier (three passes) and the single table read port (one probe
//   per cycle) set how long a draw lasts.
//   req.ready is high only while the sequencer is idle.
//   The response sits in an output register; a stalled receiver holds the
//   next draw in its final state until the register frees up.
//   Reset restores the generator seeds and register defaults; table
//   contents are undefined until loaded. Configuration via cfg_we,
//   cfg_index, cfg_data, written only while idle (user rule, unchecked).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module discrete_cdf_sampler_mwc
	import dcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	dcs_req_if.sink              req,
	dcs_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	state_t state_q, state_n;

	logic [NST_W-1:0]    num_states_q;
	logic [MULT_W-1:0]   mult_z_q, mult_w_q;
	logic [WEIGHT_W-1:0] gen_z_q, gen_w_q;
	logic [WEIGHT_W-1:0] top_q, word_q;
	logic [IDX_W-1:0]    lo_q, hi_q, mid_q;
	logic                rsp_valid_q;
	logic [IDX_W-1:0]    rsp_idx_q;
	logic [WEIGHT_W-1:0] rsp_word_q;

	logic                req_fire, draw_fire, load_fire;
	logic [IDX_W-1:0]    top_idx;
	logic [IDX_W-1:0]    raddr;
	logic [WEIGHT_W-1:0] rdata;
	logic                mul_en;
	logic [WEIGHT_W-1:0] mul_a, mul_b, mul_c;
	logic [PROD_W-1:0]   mul_p;
	logic [WEIGHT_W-1:0] word_n;
	logic                go_right, more;
	logic [IDX_W-1:0]    lo_n, hi_n, mid_n, mid_first;
	logic                rsp_free;

	assign req_fire  = req.valid & req.ready;
	assign draw_fire = req_fire & (req.kind == KIND_DRAW);
	assign load_fire = req_fire & (req.kind == KIND_LOAD);
	assign rsp_free  = ~rsp_valid_q | rsp.ready;

	// last searched entry: num_states clamped to 1..MAX_STATES, minus one
	always_comb begin
		if (num_states_q == '0) begin
			top_idx = '0;
		end else if (num_states_q > NST_W'(MAX_STATES)) begin
			top_idx = IDX_W'(MAX_STATES - 1);
		end else begin
			top_idx = IDX_W'(num_states_q - NST_W'(1));
		end
	end

	// new random word as the second generator step lands
	assign word_n = {gen_z_q[15:0], mul_p[15:0]};

	// search step: go right when prod > weight * 2^32
	assign go_right = (rdata < mul_p[PROD_W-1:WEIGHT_W]) ||
		((rdata == mul_p[PROD_W-1:WEIGHT_W]) && (mul_p[WEIGHT_W-1:0] != '0));
	assign lo_n = go_right ? mid_q + IDX_W'(1) : lo_q;
	assign hi_n = go_right ? hi_q : mid_q;
	assign more = lo_n < hi_n;
	assign mid_n = IDX_W'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);
	assign mid_first = IDX_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	// table and shared multiplier
	dcs_ram u_ram (
		.clk   (clk),
		.we    (load_fire),
		.waddr (req.entry_index),
		.wdata (req.cumulative_weight),
		.raddr (raddr),
		.rdata (rdata)
	);

	dcs_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.c   (mul_c),
		.p   (mul_p)
	);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (draw_fire) begin
					state_n = S_GZ;
				end
			end
			S_GZ:   state_n = S_GW;
			S_GW:   state_n = S_PROD;
			S_PROD: state_n = (hi_q == '0) ? S_DONE : S_SRCH;
			S_SRCH: begin
				if (!more) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and table read address
	always_comb begin
		mul_en = 1'b0;
		mul_a  = top_q;
		mul_b  = word_n;
		mul_c  = '0;
		raddr  = top_idx;
		unique case (state_q)
			S_IDLE: raddr = top_idx;
			S_GZ: begin
				mul_en = 1'b1;
				mul_a  = WEIGHT_W'(mult_z_q);
				mul_b  = WEIGHT_W'(gen_z_q[15:0]);
				mul_c  = WEIGHT_W'(gen_z_q[31:16]);
			end
			S_GW: begin
				mul_en = 1'b1;
				mul_a  = WEIGHT_W'(mult_w_q);
				mul_b  = WEIGHT_W'(gen_w_q[15:0]);
				mul_c  = WEIGHT_W'(gen_w_q[31:16]);
			end
			S_PROD: begin
				mul_en = 1'b1;
				mul_a  = top_q;
				mul_b  = word_n;
				raddr  = mid_first;
			end
			S_SRCH: raddr = mid_n;
			S_DONE: raddr = top_idx;
			default: raddr = top_idx;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// configuration registers and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= NUM_STATES_RST;
			mult_z_q     <= MULT_Z_RST;
			mult_w_q     <= MULT_W_RST;
			gen_z_q      <= GEN_Z_SEED;
			gen_w_q      <= GEN_W_SEED;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NUM_STATES: num_states_q <= cfg_data[NST_W-1:0];
					REG_MULT_Z:     mult_z_q     <= cfg_data[MULT_W-1:0];
					REG_MULT_W:     mult_w_q     <= cfg_data[MULT_W-1:0];
					default:        ;
				endcase
			end
			if (state_q == S_GW) begin
				gen_z_q <= mul_p[WEIGHT_W-1:0];
			end
			if (state_q == S_PROD) begin
				gen_w_q <= mul_p[WEIGHT_W-1:0];
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		if (draw_fire) begin
			lo_q <= '0;
			hi_q <= top_idx;
		end
		if (state_q == S_GZ) begin
			top_q <= rdata;
		end
		if (state_q == S_PROD) begin
			word_q <= word_n;
			mid_q  <= mid_first;
		end
		if (state_q == S_SRCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && rsp_free) begin
			rsp_idx_q  <= lo_q;
			rsp_word_q <= word_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.sample_index = 8'(rsp_idx_q);
	assign rsp.random_word  = rsp_word_q;

	// checks
	`DCS_ASSERT(a_srch_bounds, (state_q == S_SRCH) |-> (lo_q < hi_q && mid_q >= lo_q && mid_q < hi_q), "search bounds broken")
	`DCS_ASSERT(a_hi_in_table, (state_q == S_SRCH || state_q == S_DONE) |-> (hi_q <= top_idx), "search beyond last entry")
	`DCS_ASSERT(a_prod_held, (state_q == S_SRCH) |=> $stable(mul_p), "product changed during search")
	`DCS_ASSERT_ALWAYS(a_no_req_busy, (state_q != S_IDLE) |-> !req_fire, "request taken while busy")

endmodule
